### hw/rtl/mac_address_text_parser_top_assert.svh
// Assertion macros for the parser RTL.
// Each check is clocked on the given clock and is switched off during reset.
`ifndef MAC_ADDRESS_TEXT_PARSER_TOP_ASSERT_SVH
`define MAC_ADDRESS_TEXT_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MACP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("macp assertion failed");

`define MACP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("macp assertion failed");

`else

`define MACP_ASSERT(label, clk, rstn, prop)

`define MACP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### hw/rtl/macp_pkg.sv
`default_nettype none

package macp_pkg;

  // Address format, as reported on the style output.
  typedef enum logic [1:0] {
    STYLE_COLON = 2'd0,
    STYLE_DASH  = 2'd1,
    STYLE_DOT   = 2'd2,
    STYLE_NONE  = 2'd3
  } style_e;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [3:0] DIGITS_TOTAL = 4'd12;
  localparam logic [3:0] GROUP_PAIR   = 4'd2;
  localparam logic [3:0] GROUP_QUAD   = 4'd4;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned PREFIX_W = 24;

  // What one character is, as seen by the parser.
  typedef struct packed {
    logic       is_space;
    logic       is_sep;
    style_e     sep;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_class_t;

  // Digits needed in each group for a given format.
  function automatic logic [3:0] group_need(style_e mode);
    logic [3:0] need;
    case (mode)
      STYLE_COLON, STYLE_DASH: need = GROUP_PAIR;
      STYLE_DOT:               need = GROUP_QUAD;
      default:                 need = DIGITS_TOTAL;
    endcase
    return need;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/macp_char_class.sv
`default_nettype none

module macp_char_class import macp_pkg::*; (
  input  logic [7:0]  ch_i,
  output char_class_t cls_o
);

  logic [7:0] lower;

  // Setting bit 5 folds upper-case letters onto lower case.
  assign lower = ch_i | 8'h20;

  always_comb begin
    cls_o          = '0;
    cls_o.sep      = STYLE_NONE;
    cls_o.is_space = (ch_i == CH_SPACE) || (ch_i inside {[CH_TAB:CH_CR]});

    case (ch_i)
      CH_COLON: begin
        cls_o.is_sep = 1'b1;
        cls_o.sep    = STYLE_COLON;
      end
      CH_DASH: begin
        cls_o.is_sep = 1'b1;
        cls_o.sep    = STYLE_DASH;
      end
      CH_DOT: begin
        cls_o.is_sep = 1'b1;
        cls_o.sep    = STYLE_DOT;
      end
      default: begin
        cls_o.is_sep = 1'b0;
      end
    endcase

    if (ch_i inside {[8'h30:8'h39]}) begin
      cls_o.is_hex  = 1'b1;
      cls_o.hex_val = ch_i[3:0];
    end else if (lower inside {[8'h61:8'h66]}) begin
      cls_o.is_hex  = 1'b1;
      cls_o.hex_val = 4'd9 + lower[3:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mac_address_text_parser_top.sv
// MAC address text parser: one character enters per cycle on the input channel,
// with last marking the end of the string, and one result leaves for each string
// on the cycle after its last character has been parsed. A character passes an
// input register and then the parse logic, which updates the parse state or, on
// the last character, loads the result register; an accepted last character thus
// passes both registers before its result becomes visible. The input side takes
// an item every cycle; it stalls only while a last character waits and the
// result register still holds a result that has not been taken.
`default_nettype none

`include "mac_address_text_parser_top_assert.svh"

module mac_address_text_parser_top import macp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                valid_res_o,
  output logic [ADDR_W-1:0]   address_o,
  output logic [1:0]          style_o,
  output logic [PREFIX_W-1:0] vendor_prefix_o,
  output logic                all_ones_o,
  output logic                all_zero_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       proc;

  // Parse state.
  logic [ADDR_W-1:0] shift_q, shift_d;
  logic [3:0]        dig_cnt_q, dig_cnt_d;
  logic [3:0]        grp_cnt_q, grp_cnt_d;
  style_e            mode_q, mode_d;
  logic              seen_q, seen_d;
  logic              trail_q, trail_d;
  logic              failed_q, failed_d;

  // Result register.
  logic                out_valid_q;
  logic                res_ok_q;
  logic [ADDR_W-1:0]   res_addr_q;
  style_e              res_style_q;
  logic                res_ones_q;
  logic                res_zero_q;

  logic              ok;
  logic [ADDR_W-1:0] addr_res;

  char_class_t cls;

  macp_char_class u_class (
    .ch_i  (ch_q),
    .cls_o (cls)
  );

  // A character that ends a string needs room in the result register.
  assign proc       = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  always_comb begin
    shift_d   = shift_q;
    dig_cnt_d = dig_cnt_q;
    grp_cnt_d = grp_cnt_q;
    mode_d    = mode_q;
    seen_d    = seen_q;
    trail_d   = trail_q;
    failed_d  = failed_q;

    if (!failed_q) begin
      if (cls.is_space) begin
        if (seen_q) begin
          trail_d = 1'b1;
        end
      end else if (trail_q) begin
        failed_d = 1'b1;
      end else begin
        seen_d = 1'b1;
        if (cls.is_sep) begin
          if (mode_q != STYLE_NONE && mode_q != cls.sep) begin
            failed_d = 1'b1;
          end else begin
            // The format is locked even when this separator's group is wrong.
            mode_d = (mode_q == STYLE_NONE) ? cls.sep : mode_q;
            if (grp_cnt_q != group_need(mode_d)) begin
              failed_d = 1'b1;
            end else begin
              grp_cnt_d = '0;
            end
          end
        end else if (!cls.is_hex || dig_cnt_q == DIGITS_TOTAL) begin
          failed_d = 1'b1;
        end else begin
          shift_d   = {shift_q[ADDR_W-5:0], cls.hex_val};
          dig_cnt_d = dig_cnt_q + 4'd1;
          grp_cnt_d = grp_cnt_q + 4'd1;
        end
      end
    end

    ok = !failed_d && seen_d && dig_cnt_d == DIGITS_TOTAL &&
         grp_cnt_d == group_need(mode_d);
    addr_res = ok ? shift_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      dig_cnt_q <= '0;
      grp_cnt_q <= '0;
      mode_q    <= STYLE_NONE;
      seen_q    <= 1'b0;
      trail_q   <= 1'b0;
      failed_q  <= 1'b0;
    end else if (proc) begin
      if (last_q) begin
        shift_q   <= '0;
        dig_cnt_q <= '0;
        grp_cnt_q <= '0;
        mode_q    <= STYLE_NONE;
        seen_q    <= 1'b0;
        trail_q   <= 1'b0;
        failed_q  <= 1'b0;
      end else begin
        shift_q   <= shift_d;
        dig_cnt_q <= dig_cnt_d;
        grp_cnt_q <= grp_cnt_d;
        mode_q    <= mode_d;
        seen_q    <= seen_d;
        trail_q   <= trail_d;
        failed_q  <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      res_ok_q    <= ok;
      res_addr_q  <= addr_res;
      res_style_q <= mode_d;
      res_ones_q  <= ok && (&addr_res);
      res_zero_q  <= ok && (addr_res == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign valid_res_o     = res_ok_q;
  assign address_o       = res_addr_q;
  assign style_o         = res_style_q;
  assign vendor_prefix_o = res_addr_q[ADDR_W-1 -: PREFIX_W];
  assign all_ones_o      = res_ones_q;
  assign all_zero_o      = res_zero_q;

  `MACP_ASSERT(a_digit_bound, clk_i, rst_ni, dig_cnt_q <= DIGITS_TOTAL)
  `MACP_ASSERT(a_invalid_zero, clk_i, rst_ni,
               !(out_valid_o && !valid_res_o) || address_o == '0)
  `MACP_ASSERT(a_ones_valid, clk_i, rst_ni,
               !(out_valid_o && all_ones_o) || (valid_res_o && (&vendor_prefix_o)))
  `MACP_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, proc && last_q,
                    dig_cnt_q == '0 && !failed_q && !seen_q && mode_q == STYLE_NONE)
  `MACP_ASSERT_NEXT(a_result_drains, clk_i, rst_ni,
                    out_valid_o && out_ready_i && !(proc && last_q), !out_valid_o)

endmodule

`default_nettype wire

### sim/mac_address_text_parser_top_test.sv
`timescale 1ns / 100ps

import macp_pkg::*;

localparam logic [7:0] CH_LF = 8'h0A;
localparam logic [7:0] CH_VT = 8'h0B;
localparam logic [7:0] CH_FF = 8'h0C;

class mac_text_scoreboard;
  typedef struct {
    logic        valid_res;
    logic [47:0] address;
    style_e      style;
    logic [23:0] vendor_prefix;
    logic        all_ones;
    logic        all_zero;
  } mac_result_t;

  logic [47:0] shifted_addr;
  int unsigned digits_seen;
  int unsigned group_digits;
  style_e      locked_style;
  bit          text_started;
  bit          trailing_ws;
  bit          text_failed;
  mac_result_t results_due[$];
  int unsigned mismatches;

  function new();
    clear_parse();
    mismatches = 0;
  endfunction

  function void clear_parse();
    shifted_addr = '0;
    digits_seen  = 0;
    group_digits = 0;
    locked_style = STYLE_NONE;
    text_started = 1'b0;
    trailing_ws  = 1'b0;
    text_failed  = 1'b0;
  endfunction

  function bit is_whitespace(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function int unsigned digits_per_group(input style_e mode);
    case (mode)
      STYLE_COLON, STYLE_DASH: return GROUP_PAIR;
      STYLE_DOT:               return GROUP_QUAD;
      default:                 return DIGITS_TOTAL;
    endcase
  endfunction

  function bit hex_value(input logic [7:0] c, output logic [3:0] nib);
    nib = '0;
    if (c >= "0" && c <= "9") begin
      nib = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      nib = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      nib = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void consume_char(input logic [7:0] c);
    logic [3:0] nib;
    bit         is_sep;
    style_e     sep;
    is_sep = 1'b1;
    if (is_whitespace(c)) begin
      if (text_started) trailing_ws = 1'b1;
      return;
    end
    if (trailing_ws) begin
      text_failed = 1'b1;
      return;
    end
    text_started = 1'b1;
    case (c)
      CH_COLON: sep = STYLE_COLON;
      CH_DASH:  sep = STYLE_DASH;
      CH_DOT:   sep = STYLE_DOT;
      default: begin
        is_sep = 1'b0;
        sep = STYLE_NONE;
      end
    endcase
    if (is_sep) begin
      // The first separator fixes the format for the rest of the string.
      if (locked_style == STYLE_NONE) begin
        locked_style = sep;
      end else if (locked_style != sep) begin
        text_failed = 1'b1;
        return;
      end
      if (group_digits != digits_per_group(locked_style)) begin
        text_failed = 1'b1;
        return;
      end
      group_digits = 0;
      return;
    end
    if (!hex_value(c, nib) || digits_seen >= DIGITS_TOTAL) begin
      text_failed = 1'b1;
      return;
    end
    shifted_addr = {shifted_addr[43:0], nib};
    digits_seen++;
    group_digits++;
  endfunction

  function void note_char(input logic [7:0] c, input logic is_last);
    mac_result_t r;
    bit          ok;
    if (!text_failed) consume_char(c);
    if (!is_last) return;
    ok = !text_failed && text_started && digits_seen == DIGITS_TOTAL &&
         group_digits == digits_per_group(locked_style);
    r.valid_res     = ok;
    r.address       = ok ? shifted_addr : '0;
    r.style         = locked_style;
    r.vendor_prefix = r.address[47:24];
    r.all_ones      = ok && (r.address == '1);
    r.all_zero      = ok && (r.address == '0);
    results_due.push_back(r);
    clear_parse();
  endfunction

  task report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task compare_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task check_result(input logic v, input logic [47:0] a, input logic [1:0] s,
                    input logic [23:0] p, input logic o, input logic z);
    mac_result_t e;
    if (results_due.size() == 0) begin
      report_mismatch("result arrived with no string pending");
      return;
    end
    e = results_due.pop_front();
    compare_field("valid_res", v, e.valid_res);
    compare_field("address", a, e.address);
    compare_field("style", s, e.style);
    compare_field("vendor_prefix", p, e.vendor_prefix);
    compare_field("all_ones", o, e.all_ones);
    compare_field("all_zero", z, e.all_zero);
  endtask
endclass

module mac_address_text_parser_top_test;
  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  ch_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic [47:0] address_o;
  logic [1:0]  style_o;
  logic [23:0] vendor_prefix_o;
  logic        all_ones_o;
  logic        all_zero_o;

  mac_text_scoreboard sb = new();
  logic [7:0]  text_buf[$];
  bit          quiet_tail = 1'b0;
  int unsigned gap_pct = 20;
  int unsigned live_items = 0;
  int unsigned strings_sent = 0;

  mac_address_text_parser_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .ch_i            (ch_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .valid_res_o     (valid_res_o),
    .address_o       (address_o),
    .style_o         (style_o),
    .vendor_prefix_o (vendor_prefix_o),
    .all_ones_o      (all_ones_o),
    .all_zero_o      (all_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("FAIL mac_address_text_parser_top");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] base;
    if (v < 4'd10) base = "0";
    else if ($urandom_range(0, 1) == 0) base = "a" - 8'd10;
    else base = "A" - 8'd10;
    return base + {4'd0, v};
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 8))
      0: return CH_COLON;
      1: return CH_DASH;
      2: return CH_DOT;
      3: return ws_char();
      4: return hex_char(4'($urandom_range(0, 15)));
      5: return "g";
      6: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] sep_char(input style_e fmt);
    case (fmt)
      STYLE_COLON: return CH_COLON;
      STYLE_DASH:  return CH_DASH;
      default:     return CH_DOT;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last);
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    live_items++;
    sb.note_char(c, is_last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
    strings_sent++;
  endtask

  task automatic hold_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.results_due.size() != 0);
  endtask

  task automatic build_address_text();
    logic [63:0] raw;
    logic [47:0] mac;
    style_e      fmt;
    int          n;
    raw = {$urandom(), $urandom()};
    mac = raw[47:0];
    case ($urandom_range(0, 9))
      0: mac = '1;
      1: mac = '0;
      default: ;
    endcase
    fmt = style_e'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) text_buf.push_back(ws_char());
    for (int i = 11; i >= 0; i--) begin
      text_buf.push_back(hex_char(mac[i*4 +: 4]));
      n = 12 - i;
      if (n < 12) begin
        if ((fmt == STYLE_COLON || fmt == STYLE_DASH) && n % 2 == 0)
          text_buf.push_back(sep_char(fmt));
        else if (fmt == STYLE_DOT && n % 4 == 0)
          text_buf.push_back(sep_char(fmt));
      end
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) text_buf.push_back(ws_char());
  endtask

  // One mutation of a well-formed string; most of them make it invalid.
  task automatic break_text();
    int unsigned idx;
    idx = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 5))
      0: text_buf[idx] = odd_char();
      1: if (text_buf.size() > 1) text_buf.delete(idx);
      2: text_buf.insert(idx, odd_char());
      3: text_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      4: while (text_buf.size() > idx + 1) void'(text_buf.pop_back());
      default: begin
        text_buf.push_back(CH_SPACE);
        text_buf.push_back(odd_char());
      end
    endcase
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 16)) begin
      if ($urandom_range(0, 1) == 0) text_buf.push_back(odd_char());
      else text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_chars(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(valid_res_o, address_o, style_o, vendor_prefix_o,
                      all_ones_o, all_zero_o);
  end

  initial begin
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (quiet_tail) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(20, 80)) @(posedge clk_i);
        else repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings: byte extremes, whitespace only, mixed separators,
    // a long group, and text after trailing whitespace.
    text_buf.push_back(8'h00);
    send_text();
    text_buf.push_back(8'hFF);
    send_text();
    text_buf.push_back(CH_SPACE);
    text_buf.push_back(CH_TAB);
    text_buf.push_back(CH_LF);
    text_buf.push_back(CH_VT);
    text_buf.push_back(CH_FF);
    text_buf.push_back(CH_CR);
    send_text();
    push_chars("12:3.");
    send_text();
    push_chars("123:");
    send_text();
    push_chars(" a b");
    send_text();
    hold_for_results();

    while (live_items < 700) begin
      if (live_items > 600) quiet_tail = 1'b1;
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      if (!quiet_tail && strings_sent % 16 == 5) hold_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_address_text();
      end else if (pick < 85) begin
        build_address_text();
        break_text();
      end else begin
        build_noise();
      end
      send_text();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.results_due.size() != 0);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS mac_address_text_parser_top");
    end else begin
      $display("FAIL mac_address_text_parser_top");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/macp_pkg.sv
hw/rtl/macp_char_class.sv
hw/rtl/mac_address_text_parser_top.sv
sim/mac_address_text_parser_top_test.sv
